@@ rtl/dm1fb_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the DM1 broadcaster.
package dm1fb_pkg;

  localparam int CODE_SLOTS  = 32;
  localparam int FRAME_BYTES = 136;
  localparam int SLOT_W      = $clog2(CODE_SLOTS);
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = 6;
  localparam int CFG_AW      = 8;
  localparam int CFG_DW      = 16;

  localparam logic [CFG_AW-1:0] CFG_HIGH   = 8'd0;
  localparam logic [CFG_AW-1:0] CFG_MIDDLE = 8'd1;
  localparam logic [CFG_AW-1:0] CFG_GAP    = 8'd2;
  localparam logic [CFG_AW-1:0] CFG_PERIOD = 8'd3;

  localparam logic [7:0]  GAP_RESET    = 8'd6;
  localparam logic [15:0] PERIOD_RESET = 16'd100;

  localparam logic [7:0] DM1_LAMP     = 8'h04;
  localparam logic [7:0] FILL_BYTE    = 8'hFF;
  localparam logic [7:0] TP_CM_BAM    = 8'h20;
  localparam logic [7:0] PGN_LSB      = 8'hCA;
  localparam logic [7:0] PGN_MID      = 8'hFE;
  localparam logic [7:0] PGN_MSB      = 8'h00;
  localparam int         TP_DT_BYTES  = 7;
  localparam int         SHORT_CLEAR  = 21;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_BAM    = 2'd1,
    KIND_TPDT   = 2'd2
  } kind_e;

  typedef struct packed {
    logic in_ready;
    logic clear_wr;
    logic select;
    logic sort_step;
    logic build_step;
    logic eval;
    logic read_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_tick;
    logic changed;
    logic sort_last;
    logic build_last;
    logic emit_tp;
    logic read_last;
    logic finish_ok;
  } sts_t;

endpackage

@@ rtl/dm1fb_if.sv @@
// Valid/ready channel interfaces: input items, result items and register writes.
interface dm1fb_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [dm1fb_pkg::SLOT_W-1:0] code_index;
  logic [7:0]                   code_value;
  logic [31:0]                  error_status;
  logic [dm1fb_pkg::CNT_W-1:0]  fault_count;
  modport source (output valid, action, code_index, code_value, error_status, fault_count,
                  input ready);
  modport sink (input valid, action, code_index, code_value, error_status, fault_count,
                output ready);
endinterface

interface dm1fb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic [63:0] payload;
  modport source (output valid, frame_kind, payload, input ready);
  modport sink (input valid, frame_kind, payload, output ready);
endinterface

interface dm1fb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dm1fb_pkg::CFG_AW-1:0] addr;
  logic [dm1fb_pkg::CFG_DW-1:0] wdata;
  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

@@ rtl/dm1fb_ram.sv @@
// Generic single-port RAM with registered read.
module dm1fb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 136
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dm1fb_datapath.sv @@
// Datapath: registers, code table, sort lanes, frame store build and frame assembly.
module dm1fb_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dm1fb_pkg::cmd_t  cmd_i,
  output dm1fb_pkg::sts_t  sts_o,
  dm1fb_in_if.sink         in_ch,
  dm1fb_out_if.source      out_ch,
  dm1fb_cfg_if.sink        cfg_ch
);

  localparam int AW = dm1fb_pkg::FB_AW;
  localparam int NS = dm1fb_pkg::CODE_SLOTS;

  logic [7:0]  cfg_high_q, cfg_mid_q, cfg_gap_q;
  logic [15:0] cfg_period_q;

  logic [7:0] tbl_q [NS];
  logic [7:0] srt_q [NS];
  logic [7:0] srt_d [NS];

  logic [31:0]                  status_q, last_status_q;
  logic [dm1fb_pkg::CNT_W-1:0]  cnt_q, last_cnt_q, cnt_sat;
  logic [7:0]                   pkt_q, ab_q, ap_q, mc_q, gap_q;
  logic [15:0]                  period_q;
  logic [AW-1:0]                bp_q, clr_q, k_q;
  logic [2:0]                   m_q;
  logic                         pad_done_q;
  logic [dm1fb_pkg::SLOT_W-1:0] pass_q;
  logic [2:0]                   rd_q;
  logic [10:0]                  rd_base_q, rd_addr;
  logic                         oob_q;
  logic                         em_q, out_valid_q;
  logic [1:0]                   kind_q, out_kind_q;
  logic [63:0]                  pay_q, out_pay_q;

  logic          in_acc, cfg_acc, cnt_gt1, cnt_chg, req, do_single, do_bam, do_tp;
  logic [7:0]    gap_inc, ab_new, ap_new, mc_next;
  logic [15:0]   period_inc;
  logic [8:0]    bp9, q9, entry_end;
  logic [7:0]    bwr;
  logic          pad_hit;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [63:0]   pay_fix;
  logic [1:0]    kind_fix;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = cmd_i.in_ready;
  assign cfg_ch.ready = 1'b1;

  assign cnt_sat = (in_ch.fault_count > dm1fb_pkg::CNT_W'(NS)) ?
                   dm1fb_pkg::CNT_W'(NS) : in_ch.fault_count;

  // tick evaluation
  assign cnt_gt1   = cnt_q > dm1fb_pkg::CNT_W'(1);
  assign cnt_chg   = last_cnt_q != cnt_q;
  assign gap_inc   = gap_q + 8'd1;
  assign req       = gap_inc >= cfg_gap_q;
  assign ab_new    = cnt_chg ? ({cnt_q, 2'b00} + 8'd2) : ab_q;
  assign ap_new    = cnt_chg ? pkt_q : ap_q;
  assign do_single = !cnt_gt1 && (mc_q == 8'd0);
  assign do_bam    = cnt_gt1 && (mc_q == 8'd0);
  assign do_tp     = cnt_gt1 && (mc_q != 8'd0) && (mc_q <= pkt_q) && req;

  always_comb begin
    pay_fix  = '0;
    kind_fix = dm1fb_pkg::KIND_TPDT;
    if (do_single) begin
      kind_fix = dm1fb_pkg::KIND_SINGLE;
      if (cnt_q == '0) begin
        pay_fix = {{3{dm1fb_pkg::FILL_BYTE}}, 24'h0, dm1fb_pkg::FILL_BYTE, 8'h00};
      end else begin
        pay_fix = {{3{dm1fb_pkg::FILL_BYTE}}, srt_q[0], cfg_mid_q, cfg_high_q,
                   dm1fb_pkg::FILL_BYTE, dm1fb_pkg::DM1_LAMP};
      end
    end else if (do_bam) begin
      kind_fix = dm1fb_pkg::KIND_BAM;
      pay_fix  = {dm1fb_pkg::PGN_MSB, dm1fb_pkg::PGN_MID, dm1fb_pkg::PGN_LSB,
                  dm1fb_pkg::FILL_BYTE, ap_new, 8'h00, ab_new, dm1fb_pkg::TP_CM_BAM};
    end else begin
      pay_fix = {56'h0, mc_q};
    end
  end

  // frame store build byte
  assign bp9       = {{(9-AW){1'b0}}, bp_q};
  assign q9        = bp9 - 9'd2;
  assign entry_end = {1'b0, cnt_q, 2'b00} + 9'd2;
  assign pad_hit   = pad_done_q || (m_q == 3'd0);

  always_comb begin
    bwr = 8'h00;
    if (cnt_gt1) begin
      if (bp9 == 9'd0) begin
        bwr = dm1fb_pkg::DM1_LAMP;
      end else if (bp9 == 9'd1) begin
        bwr = dm1fb_pkg::FILL_BYTE;
      end else if (bp9 < entry_end) begin
        case (q9[1:0])
          2'd0:    bwr = cfg_high_q;
          2'd1:    bwr = cfg_mid_q;
          2'd2:    bwr = srt_q[q9[dm1fb_pkg::SLOT_W+1:2]];
          default: bwr = dm1fb_pkg::FILL_BYTE;
        endcase
      end else if (!pad_hit) begin
        bwr = dm1fb_pkg::FILL_BYTE;
      end
    end
  end

  // select and odd-even transposition lanes
  always_comb begin
    srt_d = srt_q;
    if (cmd_i.select) begin
      for (int i = 0; i < NS; i++) begin
        srt_d[i] = status_q[i] ? tbl_q[i] : 8'h00;
      end
    end else if (cmd_i.sort_step) begin
      for (int i = 0; i + 1 < NS; i++) begin
        if ((1'(i % 2) == pass_q[0]) && (srt_q[i] < srt_q[i+1])) begin
          srt_d[i]   = srt_q[i+1];
          srt_d[i+1] = srt_q[i];
        end
      end
    end
  end

  assign rd_addr = rd_base_q + {8'd0, rd_q};

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 8'h00;
    ram_addr  = rd_addr[AW-1:0];
    if (cmd_i.clear_wr) begin
      ram_we   = 1'b1;
      ram_addr = clr_q;
    end else if (cmd_i.build_step) begin
      ram_we    = 1'b1;
      ram_addr  = bp_q;
      ram_wdata = bwr;
    end
  end

  dm1fb_ram #(
    .WIDTH(8),
    .DEPTH(dm1fb_pkg::FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign mc_next    = em_q ? (mc_q + 8'd1) : mc_q;
  assign period_inc = period_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_high_q    <= '0;
      cfg_mid_q     <= '0;
      cfg_gap_q     <= dm1fb_pkg::GAP_RESET;
      cfg_period_q  <= dm1fb_pkg::PERIOD_RESET;
      for (int i = 0; i < NS; i++) begin
        tbl_q[i] <= '0;
        srt_q[i] <= '0;
      end
      last_status_q <= '0;
      last_cnt_q    <= '0;
      cnt_q         <= '0;
      pkt_q         <= 8'd1;
      ab_q          <= '0;
      ap_q          <= '0;
      mc_q          <= '0;
      gap_q         <= '0;
      period_q      <= '0;
      bp_q          <= '0;
      clr_q         <= '0;
      k_q           <= '0;
      m_q           <= '0;
      pad_done_q    <= 1'b0;
      pass_q        <= '0;
      rd_q          <= '0;
      em_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_ch.addr)
          dm1fb_pkg::CFG_HIGH:   cfg_high_q   <= cfg_ch.wdata[7:0];
          dm1fb_pkg::CFG_MIDDLE: cfg_mid_q    <= cfg_ch.wdata[7:0];
          dm1fb_pkg::CFG_GAP:    cfg_gap_q    <= cfg_ch.wdata[7:0];
          dm1fb_pkg::CFG_PERIOD: cfg_period_q <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (in_acc && in_ch.action) begin
        tbl_q[in_ch.code_index] <= in_ch.code_value;
      end
      if (in_acc && !in_ch.action) begin
        cnt_q <= cnt_sat;
      end
      if (cmd_i.clear_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      srt_q <= srt_d;
      if (cmd_i.select) begin
        last_status_q <= status_q;
        pass_q        <= '0;
        bp_q          <= '0;
        m_q           <= '0;
        k_q           <= '0;
        pad_done_q    <= 1'b0;
      end
      if (cmd_i.sort_step) begin
        pass_q <= pass_q + dm1fb_pkg::SLOT_W'(1);
      end
      if (cmd_i.build_step) begin
        bp_q <= bp_q + AW'(1);
        if (m_q == 3'd6) begin
          m_q <= '0;
          k_q <= k_q + AW'(1);
        end else begin
          m_q <= m_q + 3'd1;
        end
        if (cnt_gt1 && (bp9 >= entry_end) && pad_hit) begin
          pad_done_q <= 1'b1;
          if (!pad_done_q) begin
            pkt_q <= 8'(k_q);
          end
        end
      end
      if (cmd_i.eval) begin
        ab_q       <= ab_new;
        ap_q       <= ap_new;
        last_cnt_q <= cnt_q;
        em_q       <= do_single || do_bam || do_tp;
        rd_q       <= '0;
        if (do_bam || req) begin
          gap_q <= '0;
        end else begin
          gap_q <= gap_inc;
        end
      end
      if (cmd_i.read_step) begin
        rd_q <= rd_q + 3'd1;
      end
      if (cmd_i.finish && em_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (period_inc >= cfg_period_q) begin
          period_q <= '0;
          mc_q     <= '0;
        end else begin
          period_q <= period_inc;
          mc_q     <= mc_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !in_ch.action) begin
      status_q <= in_ch.error_status;
    end
    if (cmd_i.eval) begin
      kind_q    <= kind_fix;
      pay_q     <= pay_fix;
      rd_base_q <= ({3'b000, mc_q} - 11'd1) * 11'(dm1fb_pkg::TP_DT_BYTES);
    end
    if (cmd_i.read_step) begin
      oob_q <= rd_addr >= 11'(dm1fb_pkg::FRAME_BYTES);
      if (rd_q != 3'd0) begin
        pay_q[rd_q*8 +: 8] <= oob_q ? 8'h00 : ram_rdata;
      end
    end
    if (cmd_i.finish && em_q) begin
      out_kind_q <= kind_q;
      out_pay_q  <= pay_q;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.frame_kind = out_kind_q;
  assign out_ch.payload    = out_pay_q;

  assign sts_o.clear_last = clr_q == AW'(dm1fb_pkg::FRAME_BYTES - 1);
  assign sts_o.in_tick    = in_ch.valid && !in_ch.action;
  assign sts_o.changed    = status_q != last_status_q;
  assign sts_o.sort_last  = pass_q == dm1fb_pkg::SLOT_W'(NS - 1);
  assign sts_o.build_last = cnt_gt1 ? (bp_q == AW'(dm1fb_pkg::FRAME_BYTES - 1)) :
                                      (bp_q == AW'(dm1fb_pkg::SHORT_CLEAR - 1));
  assign sts_o.emit_tp    = do_tp;
  assign sts_o.read_last  = rd_q == 3'd7;
  assign sts_o.finish_ok  = !em_q || !out_valid_q || out_ch.ready;

endmodule

@@ rtl/dm1fb_ctrl.sv @@
// Controller state machine sequencing clear, sort, build, evaluation and store reads.
module dm1fb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dm1fb_pkg::sts_t sts_i,
  output dm1fb_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SORT,
    ST_BUILD,
    ST_EVAL,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_tick) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.changed) begin
          cmd_o.select = 1'b1;
          state_d      = ST_SORT;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_SORT: begin
        cmd_o.sort_step = 1'b1;
        if (sts_i.sort_last) state_d = ST_BUILD;
      end
      ST_BUILD: begin
        cmd_o.build_step = 1'b1;
        if (sts_i.build_last) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.emit_tp ? ST_READ : ST_FINISH;
      end
      ST_READ: begin
        cmd_o.read_step = 1'b1;
        if (sts_i.read_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.finish_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/dm1_fault_broadcast_sequencer_core.sv @@
// Top level of the DM1 fault broadcaster with BAM transport sequencing.
// After reset the frame store is cleared byte by byte, during which no item is taken
// (register writes are). A tick with an unchanged fault mask passes through check,
// evaluation and finish, with a read step added when a TP.DT packet is read out of the
// single-port frame store. A tick with a changed mask adds 32 odd-even sort passes and a
// store rebuild of 136 bytes (21 with fewer than two faults). A tick that sends a frame
// holds in its finish state while the previous result still waits unaccepted in the
// output register; otherwise the next item is taken while a result waits there.
module dm1_fault_broadcast_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  dm1fb_in_if.sink    in_ch,
  dm1fb_out_if.source out_ch,
  dm1fb_cfg_if.sink   cfg_ch
);

  dm1fb_pkg::cmd_t cmd;
  dm1fb_pkg::sts_t sts;

  dm1fb_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  dm1fb_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

endmodule
